// ===== rtl/mtsar_pkg.sv =====
// mtsar_pkg: shared types and sizes for the address remap table
// holds the command and result beat structs, the cell link struct and the fsm states
// no dependencies
package mtsar_pkg;

   localparam int DEVICES    = 4;
   localparam int CONFIGS    = 8;
   localparam int TABLE_SIZE = DEVICES * CONFIGS;
   localparam int DEV_W      = (DEVICES > 1) ? $clog2(DEVICES) : 1;
   localparam int SLOT_W     = (CONFIGS > 1) ? $clog2(CONFIGS) : 1;
   localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int SEL_W      = (IDX_W > 5) ? IDX_W : 5;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [4:0]  entry_index;
      logic        entry_valid;
      logic [15:0] entry_master_start;
      logic [15:0] entry_slave_start;
      logic [15:0] entry_length;
      logic [15:0] word_address;
      logic [15:0] word_data;
      logic        write_last;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [1:0]  device_number;
      logic [2:0]  config_slot;
      logic [15:0] slave_address;
      logic [15:0] mapped_data;
      logic        last_of_word;
      logic        end_of_write;
   } rsp_type;

   // pending match handed from a cell to its lower neighbor
   typedef struct packed {
      logic        hit;
      logic [15:0] slave_address;
   } cell_link_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

// ===== rtl/mtsar_cell.sv =====
// mtsar_cell: one remap table entry plus its pending-match slot
// window compare and address translate on capture, shift toward the head on scan
// depends on mtsar_pkg
module mtsar_cell
   import mtsar_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load_en,
   input  logic          capture,
   input  logic          shift_en,
   input  req_type       req,
   input  cell_link_type from_upper,
   output cell_link_type to_lower
);

   logic          valid_ff;
   logic [15:0]   master_start_ff;
   logic [15:0]   slave_start_ff;
   logic [15:0]   length_ff;
   cell_link_type slot_ff;
   cell_link_type slot_in;
   logic [15:0]   offset;
   logic          match;

   // offset is meaningful only when the address is at or above the window start
   assign offset = req.word_address - master_start_ff;
   assign match  = valid_ff && (req.word_address >= master_start_ff) && (offset < length_ff);

   always_comb begin
      slot_in = slot_ff;
      if (capture) begin
         slot_in.hit           = match;
         slot_in.slave_address = slave_start_ff + offset;
      end else if (shift_en) begin
         slot_in = from_upper;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         slot_ff.hit <= 1'b0;
      end else begin
         if (load_en) begin
            valid_ff <= req.entry_valid;
         end
         slot_ff.hit <= slot_in.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         master_start_ff <= req.entry_master_start;
         slave_start_ff  <= req.entry_slave_start;
         length_ff       <= req.entry_length;
      end
      slot_ff.slave_address <= slot_in.slave_address;
   end

   assign to_lower = slot_ff;

endmodule

// ===== rtl/master_to_slave_address_remap.sv =====
// master_to_slave_address_remap: top level of the master to slave address remap table
// a row of mtsar_cell entries, scan control and the registered result beat
// depends on mtsar_pkg and mtsar_cell
//
//   channel | ports                     | direction | handshake
//   --------+---------------------------+-----------+--------------------------------
//   command | start, busy, req_item     | in        | taken when start high, busy low
//   result  | rsp_valid, rsp_item       | out       | one-cycle strobe, always taken
//
// a load beat writes the entry at the accepting edge, and its no-hit result is
// registered and shows in the next cycle, with busy staying low
// a write beat compares the word against every cell at once at the accepting
// edge, then the pending matches shift down the cell row one cell per cycle;
// the scan ends right after the highest matching entry leaves cell 0,
// or after its no-hit result when nothing matched
// synchronous reset marks every entry invalid and returns the scan to idle
// the result side has no back-pressure: each result beat lives for one cycle only
module master_to_slave_address_remap
   import mtsar_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   state_type             state_ff;
   state_type             state_in;
   logic [DEV_W-1:0]      dev_ff;
   logic [DEV_W-1:0]      dev_in;
   logic [SLOT_W-1:0]     slot_ff;
   logic [SLOT_W-1:0]     slot_in;
   logic [15:0]           data_ff;
   logic                  eow_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_item_ff;
   rsp_type               rsp_item_in;

   logic                  accept;
   logic                  capture;
   logic                  shift_en;
   logic [TABLE_SIZE-1:0] load_en;
   logic [TABLE_SIZE-1:0] hits;
   logic                  any_hit;
   logic                  rest_hit;
   cell_link_type         link [TABLE_SIZE+1];

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign capture = accept && (req_item.cmd == CMD_WRITE);

   // cell row, cell 0 is the head that feeds the result register
   assign link[TABLE_SIZE] = '0;

   for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_cell
      assign load_en[i] = accept && (req_item.cmd == CMD_LOAD)
                          && (SEL_W'(req_item.entry_index) == SEL_W'(i));
      assign hits[i]    = link[i].hit;

      mtsar_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .load_en    (load_en[i]),
         .capture    (capture),
         .shift_en   (shift_en),
         .req        (req_item),
         .from_upper (link[i+1]),
         .to_lower   (link[i])
      );
   end

   assign any_hit  = |hits;
   // any match still waiting behind the head cell
   assign rest_hit = |(hits >> 1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (capture) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!any_hit || (hits[0] && !rest_hit)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and scan counters
   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_item_in  = '0;
      shift_en     = 1'b0;
      dev_in       = dev_ff;
      slot_in      = slot_ff;
      case (state_ff)
         ST_IDLE: begin
            dev_in  = '0;
            slot_in = '0;
            if (accept && (req_item.cmd == CMD_LOAD)) begin
               // load acknowledge: no hit, end of write cleared
               rsp_valid_in             = 1'b1;
               rsp_item_in.last_of_word = 1'b1;
            end
         end
         ST_SCAN: begin
            shift_en = 1'b1;
            if (!any_hit) begin
               // word matched no entry
               rsp_valid_in             = 1'b1;
               rsp_item_in.last_of_word = 1'b1;
               rsp_item_in.end_of_write = eow_ff;
            end else if (hits[0]) begin
               rsp_valid_in              = 1'b1;
               rsp_item_in.hit           = 1'b1;
               rsp_item_in.device_number = 2'(dev_ff);
               rsp_item_in.config_slot   = 3'(slot_ff);
               rsp_item_in.slave_address = link[0].slave_address;
               rsp_item_in.mapped_data   = data_ff;
               rsp_item_in.last_of_word  = !rest_hit;
               rsp_item_in.end_of_write  = eow_ff;
            end
            // head index walks device major, slot minor
            if (slot_ff == SLOT_W'(CONFIGS - 1)) begin
               slot_in = '0;
               dev_in  = dev_ff + 1'b1;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dev_ff      <= dev_in;
      slot_ff     <= slot_in;
      rsp_item_ff <= rsp_item_in;
      if (capture) begin
         data_ff <= req_item.word_data;
         eow_ff  <= req_item.write_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== dv/remap_checker.sv =====
`timescale 1ns / 1ps
// remap_checker: watches the command and result channels of the remap table
// keeps its own copy of the route table and compares every result beat; uses mtsar_pkg
module remap_checker
   import mtsar_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_valid,
   input  rsp_type rsp_item,
   output int      errors,
   output int      pending,
   output int      results_seen,
   output int      hits_seen
);

   localparam int PRINT_CAP = 40;

   logic        route_valid  [TABLE_SIZE];
   logic [15:0] route_mstart [TABLE_SIZE];
   logic [15:0] route_sstart [TABLE_SIZE];
   logic [15:0] route_len    [TABLE_SIZE];

   rsp_type due_results[$];

   initial begin
      errors = 0;
      pending = 0;
      results_seen = 0;
      hits_seen = 0;
   end

   task automatic report_mismatch(input string what);
      if (errors < PRINT_CAP)
         $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s got %h expected %h",
                                   results_seen, name, got, want));
   endtask

   // table update for a load, translated words for a write
   task automatic predict_beat(input req_type b);
      rsp_type r;
      rsp_type hits[$];
      int off;
      r = '0;
      if (b.cmd == CMD_LOAD) begin
         if (int'(b.entry_index) < TABLE_SIZE) begin
            route_valid[b.entry_index]  = b.entry_valid;
            route_mstart[b.entry_index] = b.entry_master_start;
            route_sstart[b.entry_index] = b.entry_slave_start;
            route_len[b.entry_index]    = b.entry_length;
         end
         r.last_of_word = 1'b1;
         due_results.push_back(r);
      end else begin
         for (int i = 0; i < TABLE_SIZE && hits.size() < 32; i++) begin
            if (!route_valid[i] || b.word_address < route_mstart[i])
               continue;
            // no wrap here: a window running past the top ends at the top
            off = int'(b.word_address) - int'(route_mstart[i]);
            if (off >= int'(route_len[i]))
               continue;
            r.hit           = 1'b1;
            r.device_number = 2'(i / CONFIGS);
            r.config_slot   = 3'(i % CONFIGS);
            r.slave_address = route_sstart[i] + 16'(off);
            r.mapped_data   = b.word_data;
            r.last_of_word  = 1'b0;
            r.end_of_write  = b.write_last;
            hits.push_back(r);
         end
         if (hits.size() == 0) begin
            r.last_of_word = 1'b1;
            r.end_of_write = b.write_last;
            due_results.push_back(r);
         end else begin
            hits[hits.size() - 1].last_of_word = 1'b1;
            foreach (hits[k])
               due_results.push_back(hits[k]);
         end
      end
   endtask

   task automatic check_beat(input rsp_type got);
      rsp_type want;
      results_seen++;
      if (got.hit === 1'b1)
         hits_seen++;
      if (due_results.size() == 0) begin
         report_mismatch($sformatf("result %0d arrived with nothing expected",
                                   results_seen));
         return;
      end
      want = due_results.pop_front();
      compare_field("hit", 16'(got.hit), 16'(want.hit));
      compare_field("device_number", 16'(got.device_number), 16'(want.device_number));
      compare_field("config_slot", 16'(got.config_slot), 16'(want.config_slot));
      compare_field("slave_address", got.slave_address, want.slave_address);
      compare_field("mapped_data", got.mapped_data, want.mapped_data);
      compare_field("last_of_word", 16'(got.last_of_word), 16'(want.last_of_word));
      compare_field("end_of_write", 16'(got.end_of_write), 16'(want.end_of_write));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         due_results.delete();
         for (int i = 0; i < TABLE_SIZE; i++) begin
            route_valid[i]  = 1'b0;
            route_mstart[i] = '0;
            route_sstart[i] = '0;
            route_len[i]    = '0;
         end
      end else begin
         if (rsp_valid !== 1'b0)
            check_beat(rsp_item);
         if (start && busy === 1'b0)
            predict_beat(req_item);
      end
      pending = due_results.size();
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// testbench: top of the remap table bench, makes clock, reset and command beats
// depends on mtsar_pkg, master_to_slave_address_remap and remap_checker
module testbench;
   import mtsar_pkg::*;

   // worst run is a few hundred beats, each up to a full write scan, plus gaps,
   // so this is many times over
   localparam int CYCLE_LIMIT = 300000;
   // wait past the longest possible write scan at the end
   localparam int DRAIN_CYCLES = TABLE_SIZE + 8;
   localparam int PHASE_BEATS = 100;
   // most windows and words land in this region so that hits are common
   localparam logic [15:0] FOCUS_BASE = 16'h4000;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   // set at each edge where a command beat was taken, read at the falling edge
   logic took = 1'b0;

   int errors;
   int pending;
   int results_seen;
   int hits_seen;
   int cycles = 0;
   int beats_sent = 0;
   int idle_pct = 0;

   // state of the current range write run
   int          run_left = 0;
   logic [15:0] run_addr = '0;

   master_to_slave_address_remap uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   remap_checker route_check (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_item     (req_item),
      .rsp_valid    (rsp_valid),
      .rsp_item     (rsp_item),
      .errors       (errors),
      .pending      (pending),
      .results_seen (results_seen),
      .hits_seen    (hits_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      took <= !reset && start && busy === 1'b0;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
         $display("Test completed with failures");
         $finish;
      end
   end

   // random bits everywhere, so fields a command does not use still toggle
   function automatic req_type noise_beat();
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   function automatic req_type load_beat(input int idx, input logic vld,
                                         input logic [15:0] mstart,
                                         input logic [15:0] sstart,
                                         input logic [15:0] len);
      req_type b;
      b = noise_beat();
      b.cmd                = CMD_LOAD;
      b.entry_index        = 5'(idx);
      b.entry_valid        = vld;
      b.entry_master_start = mstart;
      b.entry_slave_start  = sstart;
      b.entry_length       = len;
      return b;
   endfunction

   function automatic req_type word_beat(input logic [15:0] addr, input logic [15:0] data,
                                         input logic last);
      req_type b;
      b = noise_beat();
      b.cmd          = CMD_WRITE;
      b.word_address = addr;
      b.word_data    = data;
      b.write_last   = last;
      return b;
   endfunction

   // mostly inside the focus region, now and then anywhere
   function automatic logic [15:0] pick_address();
      if ($urandom_range(0, 4) == 0)
         return 16'($urandom);
      return FOCUS_BASE + 16'($urandom_range(0, 127));
   endfunction

   // loads with mostly short windows near the focus, and well-formed range write runs
   // broken up by stray words and by loads landing mid-run
   function automatic req_type random_beat();
      req_type     b;
      logic [15:0] mstart;
      logic [15:0] len;
      int          pick;
      if ($urandom_range(0, 99) < 30) begin
         mstart = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                              : FOCUS_BASE + 16'($urandom_range(0, 96));
         pick = $urandom_range(0, 99);
         if (pick < 10)
            len = '0;
         else if (pick < 30)
            len = 16'($urandom);
         else
            len = 16'($urandom_range(1, 24));
         return load_beat($urandom_range(0, TABLE_SIZE - 1), $urandom_range(0, 99) < 85,
                          mstart, 16'($urandom), len);
      end
      b = noise_beat();
      b.cmd = CMD_WRITE;
      if ($urandom_range(0, 99) < 15) begin
         // stray word, write_last left random
         b.word_address = pick_address();
      end else begin
         if (run_left == 0) begin
            run_addr = pick_address();
            run_left = $urandom_range(1, 8);
         end
         b.word_address = run_addr;
         run_addr++;
         run_left--;
         b.write_last = (run_left == 0);
      end
      return b;
   endfunction

   // called at a falling edge, returns at the falling edge after the beat is taken
   task automatic send_beat(input req_type b);
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) < idle_pct)
         gap = $urandom_range(1, 5);
      if (gap > 0) begin
         // idle with garbage on the bus, the block must ignore it
         start    <= 1'b0;
         req_item <= noise_beat();
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_item <= b;
      do @(negedge clock); while (!took);
      beats_sent++;
   endtask

   initial begin
      int phase_idle[4];
      phase_idle = '{0, 53, 0, 36};
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed beats, back to back
      // empty table: a word matches nothing
      send_beat(word_beat(16'h0000, 16'hFFFF, 1'b1));
      send_beat(load_beat(0, 1'b1, 16'h0010, 16'h1000, 16'd4));
      // window running off the top of the address space, slave address wraps
      send_beat(load_beat(TABLE_SIZE - 1, 1'b1, 16'hFFF0, 16'hFFFE, 16'hFFFF));
      // overlaps entry 0 at one address
      send_beat(load_beat(9, 1'b1, 16'h0012, 16'hFFFF, 16'd1));
      // unused entry and zero length entry must never match
      send_beat(load_beat(5, 1'b0, 16'h0010, 16'h2000, 16'd100));
      send_beat(load_beat(12, 1'b1, 16'h0010, 16'h3000, 16'd0));
      send_beat(load_beat(20, 1'b1, 16'hFFFF, 16'h0000, 16'd1));
      send_beat(word_beat(16'h0010, 16'h0000, 1'b0));
      send_beat(word_beat(16'h0012, 16'hA5A5, 1'b0));
      send_beat(word_beat(16'h0013, 16'h5A5A, 1'b1));
      // one past the window and one before it
      send_beat(word_beat(16'h0014, 16'h1234, 1'b1));
      send_beat(word_beat(16'h000F, 16'h4321, 1'b0));
      send_beat(word_beat(16'hFFF0, 16'h0001, 1'b0));
      send_beat(word_beat(16'hFFFF, 16'hFFFF, 1'b1));
      // invalidate entry 0 and check it is gone
      send_beat(load_beat(0, 1'b0, 16'h0010, 16'h1000, 16'd4));
      send_beat(word_beat(16'h0010, 16'h0F0F, 1'b1));
      // maximum-length window from address zero, it stops one short of the top
      send_beat(load_beat(1, 1'b1, 16'h0000, 16'hFFFF, 16'hFFFF));
      send_beat(word_beat(16'h0000, 16'hF0F0, 1'b0));
      send_beat(word_beat(16'hFFFE, 16'h8000, 1'b0));
      send_beat(word_beat(16'hFFFF, 16'h7FFF, 1'b1));

      // random phases, each with its own idle pattern on the command side
      for (int p = 0; p < 4; p++) begin
         idle_pct = phase_idle[p];
         if (p == 2) begin
            // every entry covers the focus region, so focus words hit all of them
            for (int i = 0; i < TABLE_SIZE; i++)
               send_beat(load_beat(i, 1'b1, FOCUS_BASE, 16'($urandom), 16'hFFFF));
         end
         for (int k = 0; k < PHASE_BEATS; k++)
            send_beat(random_beat());
      end

      start <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("run covered %0d command beats (loads and words, idle phases 0/53/0/36 pct)",
               beats_sent);
      $display("checked %0d result beats, %0d of them mapped hits", results_seen, hits_seen);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/mtsar_pkg.sv
rtl/mtsar_cell.sv
rtl/master_to_slave_address_remap.sv
dv/remap_checker.sv
dv/testbench.sv
